// File: rtl/core/hrwd_pkg.sv
`default_nettype none
package hrwd_pkg;
  localparam int ROWS = 256;
  localparam int LOCK_SLOTS = 4;
  localparam int ROW_W = 8;
  localparam int ID_W = 48;
  localparam int HOT_W = 16;
  localparam int THR_W = 12;

  localparam logic [2:0] FN_ACQUIRE = 3'd0;
  localparam logic [2:0] FN_TRY_EXCL = 3'd1;
  localparam logic [2:0] FN_RELEASE = 3'd2;
  localparam logic [2:0] FN_VALIDATE = 3'd3;
  localparam logic [2:0] FN_WRITE_VER = 3'd4;

  localparam logic [1:0] MODE_FREE = 2'd0;
  localparam logic [1:0] MODE_EXCL = 2'd1;
  localparam logic [1:0] MODE_SHARED = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ABORT = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  typedef struct packed {
    logic [2:0] func;
    logic [ROW_W-1:0] row_index;
    logic [ID_W-1:0] txn_id;
    logic [ID_W-1:0] stamp;
    logic is_write;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic row_is_hot;
  } rsp_t;

  // one row of the table, all slots side by side
  typedef struct packed {
    logic [1:0] mode;
    logic [LOCK_SLOTS-1:0][ID_W-1:0] slot_stamp;
    logic [LOCK_SLOTS-1:0][ID_W-1:0] slot_owner;
    logic [HOT_W-1:0] hot;
    logic [ID_W-1:0] version;
  } row_t;
endpackage
`default_nettype wire

// File: rtl/core/hot_row_wait_die_lock_table.sv
`default_nettype none
// Wait-die row lock table. Each request does a read-modify-write of one row's
// entry (mode, all holder slots, hotness, version) held in a single synchronous
// memory: the cycle after an item is accepted reads the row, the next compares
// all slots in parallel, writes back and loads the result register, and the
// next item can be accepted while the result waits. A result not yet taken
// by the receiver holds the write-back of the following item until it is
// taken. After reset a clearing pass walks all 256 rows, one a cycle, before
// the first item is accepted.
module hot_row_wait_die_lock_table
  import hrwd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [THR_W-1:0] cfg_wdata,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire req_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output rsp_t out_data
);
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  row_t mem [ROWS];
  row_t rd;
  row_t wdata;
  logic we;
  logic [ROW_W-1:0] waddr;

  logic [1:0] state;
  logic [ROW_W:0] clr_cnt;
  logic [THR_W-1:0] hot_threshold;
  req_t req;
  rsp_t rsp_next;
  row_t upd;
  logic exec_go;

  assign in_ready = (state == S_IDLE);
  // write back only once the result register is free
  assign exec_go = (state == S_EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[req.row_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      hot_threshold <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) hot_threshold <= cfg_wdata;
      if (exec_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (ROW_W+1)'(ROWS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid && in_ready) state <= S_READ;
        S_READ: state <= S_EXEC;
        S_EXEC: if (exec_go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_ready) req <= in_data;
    if (exec_go) out_data <= rsp_next;
  end

  // row update
  always_comb begin
    logic hot, older, placed, any_held;
    logic [HOT_W+3:0] ten_thr;
    upd = rd;
    rsp_next.status = ST_OK;
    hot = rd.hot > HOT_W'(hot_threshold);
    rsp_next.row_is_hot = hot;
    ten_thr = (HOT_W+4)'(hot_threshold) * (HOT_W+4)'(10);
    older = 1'b0;
    for (int i = 0; i < LOCK_SLOTS; i++)
      if (rd.slot_stamp[i] != '0 && req.stamp > rd.slot_stamp[i]) older = 1'b1;
    placed = 1'b0;
    any_held = 1'b0;
    case (req.func)
      FN_ACQUIRE: if (hot) begin
        if ((HOT_W+4)'(rd.hot) > ten_thr) upd.hot = '0;
        if (rd.mode == MODE_FREE) begin
          upd.slot_owner[0] = req.txn_id;
          upd.slot_stamp[0] = req.stamp;
          upd.mode = req.is_write ? MODE_EXCL : MODE_SHARED;
        end else if (rd.mode == MODE_EXCL || req.is_write) begin
          if (older) begin
            if (upd.hot != '1) upd.hot = upd.hot + 1'b1;
            rsp_next.status = ST_ABORT;
          end else rsp_next.status = ST_WAIT;
        end else begin
          for (int i = 0; i < LOCK_SLOTS; i++)
            if (!placed && rd.slot_stamp[i] == '0) begin
              placed = 1'b1;
              upd.slot_stamp[i] = req.stamp;
              upd.slot_owner[i] = req.txn_id;
              upd.mode = MODE_SHARED;
            end
          if (!placed) begin
            if (upd.hot != '1) upd.hot = upd.hot + 1'b1;
            rsp_next.status = ST_ABORT;
          end
        end
      end
      FN_TRY_EXCL: begin
        if (rd.mode == MODE_FREE) begin
          upd.slot_owner[0] = req.txn_id;
          upd.slot_stamp[0] = req.stamp;
          upd.mode = MODE_EXCL;
        end else begin
          if (rd.mode == MODE_EXCL && older && rd.hot != '1) upd.hot = rd.hot + 1'b1;
          rsp_next.status = ST_ABORT;
        end
      end
      FN_RELEASE: begin
        for (int i = 0; i < LOCK_SLOTS; i++) begin
          if (rd.slot_owner[i] == req.txn_id) begin
            upd.slot_stamp[i] = '0;
            upd.slot_owner[i] = '0;
            if (upd.mode == MODE_EXCL) upd.mode = MODE_FREE;
          end
          if (upd.slot_stamp[i] != '0) any_held = 1'b1;
        end
        if (!any_held) upd.mode = MODE_FREE;
      end
      FN_VALIDATE: if (rd.version != req.stamp) begin
        if (rd.hot != '1) upd.hot = rd.hot + 1'b1;
        rsp_next.status = ST_ABORT;
      end
      FN_WRITE_VER: upd.version = req.stamp;
      default: rsp_next.status = ST_ABORT;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = req.row_index;
    wdata = upd;
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_cnt[ROW_W-1:0];
      wdata = '0;
    end else if (exec_go) we = 1'b1;
  end
endmodule
`default_nettype wire

// File: tb/tb_hot_row_wait_die_lock_table.sv
`default_nettype none
module tb_hot_row_wait_die_lock_table;
  import hrwd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [THR_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  hot_row_wait_die_lock_table u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // shadow lock table
  logic [THR_W-1:0] thr;
  logic [1:0] sh_mode [ROWS];
  logic [ID_W-1:0] sh_stamp [ROWS][LOCK_SLOTS];
  logic [ID_W-1:0] sh_owner [ROWS][LOCK_SLOTS];
  logic [HOT_W-1:0] sh_hot [ROWS];
  logic [ID_W-1:0] sh_ver [ROWS];

  rsp_t lock_rsp_q[$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int i;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

  function automatic void table_clear();
    thr = '0;
    for (int r = 0; r < ROWS; r++) begin
      sh_mode[r] = MODE_FREE;
      sh_hot[r] = '0;
      sh_ver[r] = '0;
      for (int s = 0; s < LOCK_SLOTS; s++) begin
        sh_stamp[r][s] = '0;
        sh_owner[r][s] = '0;
      end
    end
  endfunction

  function automatic void raise_heat(int r);
    if (sh_hot[r] != '1) sh_hot[r] = sh_hot[r] + 1'b1;
  endfunction

  function automatic bit has_older(int r, logic [ID_W-1:0] ts);
    for (int s = 0; s < LOCK_SLOTS; s++)
      if (sh_stamp[r][s] != 0 && ts > sh_stamp[r][s]) return 1;
    return 0;
  endfunction

  function automatic rsp_t lock_predict(req_t q);
    rsp_t p;
    int r;
    int held;
    bit hot;
    bit placed;
    r = q.row_index;
    hot = {16'd0, sh_hot[r]} > {20'd0, thr};
    p.status = ST_OK;
    p.row_is_hot = hot;
    case (q.func)
      FN_ACQUIRE: begin
        if (hot) begin
          if ({16'd0, sh_hot[r]} > {20'd0, thr} * 10) sh_hot[r] = '0;
          if (sh_mode[r] == MODE_FREE) begin
            sh_owner[r][0] = q.txn_id;
            sh_stamp[r][0] = q.stamp;
            sh_mode[r] = q.is_write ? MODE_EXCL : MODE_SHARED;
          end else if (sh_mode[r] == MODE_EXCL || q.is_write) begin
            if (has_older(r, q.stamp)) begin
              raise_heat(r);
              p.status = ST_ABORT;
            end else begin
              p.status = ST_WAIT;
            end
          end else begin
            placed = 0;
            for (int s = 0; s < LOCK_SLOTS; s++) begin
              if (!placed && sh_stamp[r][s] == 0) begin
                sh_stamp[r][s] = q.stamp;
                sh_owner[r][s] = q.txn_id;
                sh_mode[r] = MODE_SHARED;
                placed = 1;
              end
            end
            if (!placed) begin
              raise_heat(r);
              p.status = ST_ABORT;
            end
          end
        end
      end
      FN_TRY_EXCL: begin
        if (sh_mode[r] == MODE_FREE) begin
          sh_owner[r][0] = q.txn_id;
          sh_stamp[r][0] = q.stamp;
          sh_mode[r] = MODE_EXCL;
        end else begin
          if (sh_mode[r] == MODE_EXCL && has_older(r, q.stamp)) raise_heat(r);
          p.status = ST_ABORT;
        end
      end
      FN_RELEASE: begin
        held = 0;
        for (int s = 0; s < LOCK_SLOTS; s++) begin
          if (sh_owner[r][s] == q.txn_id) begin
            sh_stamp[r][s] = '0;
            sh_owner[r][s] = '0;
            if (sh_mode[r] == MODE_EXCL) sh_mode[r] = MODE_FREE;
          end
          if (sh_stamp[r][s] != 0) held++;
        end
        if (held == 0) sh_mode[r] = MODE_FREE;
      end
      FN_VALIDATE: begin
        if (sh_ver[r] != q.stamp) begin
          raise_heat(r);
          p.status = ST_ABORT;
        end
      end
      FN_WRITE_VER: sh_ver[r] = q.stamp;
      default: p.status = ST_ABORT;
    endcase
    return p;
  endfunction

  // send one item; valid stays high into the next item when there is no idle cycle
  task automatic send_item(req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lock_rsp_q.push_back(lock_predict(q));
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (lock_rsp_q.size() != 0) @(posedge clk);
    while (n < 10) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic set_threshold(logic [THR_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr = v;
  endtask

  // receiver and checker
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (lock_rsp_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected item %p", out_data);
        end else begin
          rsp_t e;
          e = lock_rsp_q.pop_front();
          if (out_data.status !== e.status || out_data.row_is_hot !== e.row_is_hot) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp status %0d hot %0d, got status %0d hot %0d",
                       e.status, e.row_is_hot, out_data.status, out_data.row_is_hot);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  typedef struct {
    req_t q;
    bit known;
    rsp_t e;
  } dir_row_t;

  function automatic req_t mk(logic [2:0] f, logic [7:0] r, logic [ID_W-1:0] t,
                              logic [ID_W-1:0] s, logic w);
    req_t q;
    q.func = f;
    q.row_index = r;
    q.txn_id = t;
    q.stamp = s;
    q.is_write = w;
    return q;
  endfunction

  function automatic rsp_t rs(logic [1:0] s, logic h);
    rsp_t p;
    p.status = s;
    p.row_is_hot = h;
    return p;
  endfunction

  // random item focused on a few rows so locks collide
  function automatic req_t rand_req();
    req_t q;
    logic [2:0] f;
    int k;
    k = $urandom_range(99);
    if (k < 40) f = FN_ACQUIRE;
    else if (k < 55) f = FN_TRY_EXCL;
    else if (k < 80) f = FN_RELEASE;
    else if (k < 90) f = FN_VALIDATE;
    else if (k < 97) f = FN_WRITE_VER;
    else f = 3'($urandom_range(5, 7));
    q.func = f;
    q.row_index = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
    q.txn_id = ($urandom_range(1) == 0) ? ID_W'($urandom_range(1, 6))
                                         : {16'($urandom), 32'($urandom)} | 48'd1;
    case ($urandom_range(4))
      0: q.stamp = {16'($urandom), 32'($urandom)};
      1: q.stamp = '0;
      2: q.stamp = '1;
      default: q.stamp = ID_W'($urandom_range(8));
    endcase
    q.is_write = 1'($urandom_range(1));
    return q;
  endfunction

  dir_row_t dir_tab[$];

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    table_clear();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // cold rows at threshold 0: hot count 0 is not hot
    dir_tab.push_back('{mk(FN_ACQUIRE, 8'd0, 48'd1, 48'd5, 1'b1), 1, rs(ST_OK, 1'b0)});
    dir_tab.push_back('{mk(FN_VALIDATE, 8'd255, '1, 48'd0, 1'b0), 1, rs(ST_OK, 1'b0)});
    dir_tab.push_back('{mk(FN_VALIDATE, 8'd255, '1, '1, 1'b0), 1, rs(ST_ABORT, 1'b0)});
    dir_tab.push_back('{mk(FN_WRITE_VER, 8'd255, 48'd1, '1, 1'b1), 1, rs(ST_OK, 1'b1)});
    dir_tab.push_back('{mk(FN_VALIDATE, 8'd255, 48'd1, '1, 1'b0), 0, rs(ST_OK, 1'b0)});
    dir_tab.push_back('{mk(3'd5, 8'd1, 48'd1, 48'd1, 1'b0), 1, rs(ST_ABORT, 1'b0)});
    dir_tab.push_back('{mk(3'd7, 8'd1, '1, '1, 1'b1), 1, rs(ST_ABORT, 1'b0)});
    dir_tab.push_back('{mk(FN_TRY_EXCL, 8'd2, 48'd3, 48'd10, 1'b0), 1, rs(ST_OK, 1'b0)});
    dir_tab.push_back('{mk(FN_TRY_EXCL, 8'd2, 48'd4, 48'd20, 1'b0), 1, rs(ST_ABORT, 1'b0)});
    dir_tab.push_back('{mk(FN_TRY_EXCL, 8'd2, 48'd4, 48'd5, 1'b0), 0, rs(ST_OK, 1'b0)});
    // row 2 now hot: contend on it
    dir_tab.push_back('{mk(FN_ACQUIRE, 8'd2, 48'd5, 48'd30, 1'b1), 0, rs(ST_OK, 1'b0)});
    dir_tab.push_back('{mk(FN_ACQUIRE, 8'd2, 48'd5, 48'd1, 1'b0), 0, rs(ST_OK, 1'b0)});
    dir_tab.push_back('{mk(FN_RELEASE, 8'd2, 48'd9, 48'd0, 1'b0), 0, rs(ST_OK, 1'b0)});
    dir_tab.push_back('{mk(FN_RELEASE, 8'd2, 48'd3, 48'd0, 1'b0), 0, rs(ST_OK, 1'b0)});
    dir_tab.push_back('{mk(FN_VALIDATE, 8'd2, 48'd1, 48'd7, 1'b0), 0, rs(ST_OK, 1'b0)});
    dir_tab.push_back('{mk(FN_VALIDATE, 8'd2, 48'd1, 48'd7, 1'b0), 0, rs(ST_OK, 1'b0)});
    // shared fill past slot count, zero stamp grant
    for (int s = 0; s < 6; s++)
      dir_tab.push_back('{mk(FN_ACQUIRE, 8'd2, 48'(s + 10), (s == 1) ? 48'd0 : 48'(s + 3),
                             1'b0), 0, rs(ST_OK, 1'b0)});
    dir_tab.push_back('{mk(FN_ACQUIRE, 8'd2, 48'd20, 48'd2, 1'b1), 0, rs(ST_OK, 1'b0)});
    dir_tab.push_back('{mk(FN_TRY_EXCL, 8'd2, 48'd21, 48'd99, 1'b0), 0, rs(ST_OK, 1'b0)});

    foreach (dir_tab[j]) begin
      rsp_t e;
      e = lock_predict(dir_tab[j].q);
      if (dir_tab[j].known && e != dir_tab[j].e) begin
        errors++;
        if (errors <= 10) $display("table row %0d disagrees with predictor", j);
      end
      // shadow already updated above, so drive the item directly
      in_valid <= 1'b1;
      in_data <= dir_tab[j].q;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      lock_rsp_q.push_back(e);
    end

    // random phases over several thresholds
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_threshold('0);
        1: set_threshold(12'd1);
        2: set_threshold(12'd3);
        3: set_threshold('1);
        4: set_threshold(12'd2);
        5: set_threshold(12'($urandom_range(6)));
        6: set_threshold('0);
        default: set_threshold(12'd1);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 81; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 81; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (i = 0; i < 160; i++) begin
        send_item(rand_req());
        if (ph == 2 && i == 80) begin
          in_valid <= 1'b0;
          while (lock_rsp_q.size() != 0) @(posedge clk);
        end
      end
    end

    recv_stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
